// ----- hdl/bsrc_pkg.sv -----
// ----------------------------------------------------------------------------
// Banker's check package
// Shared sizes, codes and helper types for the deadlock-avoidance engine.
// ----------------------------------------------------------------------------
`default_nettype none
package bsrc_pkg;
   localparam int MAX_PROCS     = 16;
   localparam int MAX_RES_TYPES = 8;
   localparam int COUNT_BITS    = 16;

   localparam int PROC_W = $clog2(MAX_PROCS);
   localparam int RES_W  = $clog2(MAX_RES_TYPES);
   localparam int ADDR_W = PROC_W + RES_W;
   localparam int DEPTH  = MAX_PROCS * MAX_RES_TYPES;
   localparam int PCNT_W = $clog2(MAX_PROCS + 1);
   localparam int RCNT_W = $clog2(MAX_RES_TYPES + 1);
   localparam int WORK_W = COUNT_BITS + PROC_W + 1;

   localparam int FUNC_W  = 3;
   localparam int PIDX_W  = 4;
   localparam int RIDX_W  = 3;
   localparam int VALUE_W = 16;
   localparam int STAT_W  = 2;
   localparam int SEQP_W  = 4;
   localparam int NPROC_W = 5;
   localparam int NRES_W  = 4;
   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = 5;

   typedef enum logic [FUNC_W-1:0] {
      FUNC_WR_MAX   = 3'd0,
      FUNC_WR_ALLOC = 3'd1,
      FUNC_WR_AVAIL = 3'd2,
      FUNC_STAGE    = 3'd3,
      FUNC_CHECK    = 3'd4,
      FUNC_GRANT    = 3'd5
   } func_type;

   typedef enum logic [STAT_W-1:0] {
      STAT_SAFE       = 2'd0,
      STAT_UNSAFE     = 2'd1,
      STAT_OVER_NEED  = 2'd2,
      STAT_OVER_AVAIL = 2'd3
   } status_type;

   localparam logic [CSR_IDX_W-1:0] CSR_NUM_PROCS = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_NUM_RES   = 1'd1;

   typedef logic [COUNT_BITS-1:0] count_type;
   typedef logic [WORK_W-1:0]     work_type;
endpackage
`default_nettype wire

// ----- hdl/bsrc_req_if.sv -----
// ----------------------------------------------------------------------------
// Request channel
// Carries one engine operation per transaction.
// ----------------------------------------------------------------------------
`default_nettype none
interface bsrc_req_if import bsrc_pkg::*; ();
   logic               valid;
   logic               ready;
   logic [FUNC_W-1:0]  func;
   logic [PIDX_W-1:0]  proc_index;
   logic [RIDX_W-1:0]  res_index;
   logic [VALUE_W-1:0] value;
   modport source (output valid, func, proc_index, res_index, value, input ready);
   modport sink   (input valid, func, proc_index, res_index, value, output ready);
endinterface
`default_nettype wire

// ----- hdl/bsrc_rsp_if.sv -----
// ----------------------------------------------------------------------------
// Result channel
// Carries one status or safe-sequence entry per transaction.
// ----------------------------------------------------------------------------
`default_nettype none
interface bsrc_rsp_if import bsrc_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [STAT_W-1:0] status;
   logic [SEQP_W-1:0] seq_process;
   logic              last;
   modport source (output valid, status, seq_process, last, input ready);
   modport sink   (input valid, status, seq_process, last, output ready);
endinterface
`default_nettype wire

// ----- hdl/bsrc_csr_if.sv -----
// ----------------------------------------------------------------------------
// Register write channel
// Carries one register index and its write data per transaction.
// ----------------------------------------------------------------------------
`default_nettype none
interface bsrc_csr_if import bsrc_pkg::*; ();
   logic                  valid;
   logic                  ready;
   logic [CSR_IDX_W-1:0]  index;
   logic [CSR_DATA_W-1:0] data;
   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface
`default_nettype wire

// ----- hdl/bankers_safety_and_request_check_top.sv -----
// ----------------------------------------------------------------------------
// Banker's safety and request check
// Holds maximum-claim and allocation tables in RAM and runs safety scans
// and request grants one resource element at a time.
// ----------------------------------------------------------------------------
// Channel   Direction  Contents
// req_chan  in         func, proc_index, res_index, value
// rsp_chan  out        status, seq_process, last
// csr_chan  in         index, data (process and resource counts)
//
// Table, vector and staging writes are accepted back to back.
// A check loads work from the available vector, then makes repeated passes
// of the process loop, comparing each resource element of need against work
// and adding a fitting process's allocation into work; a grant first tests
// each element against need and availability, decides, then updates the
// allocation and available vectors, rolling back if the state is unsafe.
// Reset is synchronous; table entries read as zero until written.
// A stalled result holds the engine in its emit state.
// ----------------------------------------------------------------------------
`default_nettype none
module bankers_safety_and_request_check_top import bsrc_pkg::*; (
   input wire logic clock,
   input wire logic reset,
   bsrc_req_if.sink   req_chan,
   bsrc_rsp_if.source rsp_chan,
   bsrc_csr_if.sink   csr_chan
);
   typedef enum logic [3:0] {
      ST_IDLE, ST_GRD, ST_GEV, ST_GEND, ST_ARD, ST_AEV, ST_INIT, ST_SRD, ST_SEV,
      ST_WRD, ST_WEV, ST_NEXT, ST_RRD, ST_REV, ST_EMIT_SEQ, ST_EMIT_ONE
   } state_type;

   state_type state_ff;
   logic [NPROC_W-1:0] num_procs_ff;
   logic [NRES_W-1:0]  num_res_ff;
   count_type avail_ff [MAX_RES_TYPES];
   count_type req_ff   [MAX_RES_TYPES];
   work_type  work_ff  [MAX_RES_TYPES];
   logic [MAX_PROCS-1:0] fin_ff;
   logic [PROC_W-1:0]    seq_ff [MAX_PROCS];
   logic [DEPTH-1:0]     max_vld_ff, alloc_vld_ff;
   logic max_rv_ff, alloc_rv_ff;
   logic grant_ff, found_ff, need_err_ff, avail_err_ff;
   logic [PROC_W-1:0] proc_ff, i_ff, k_ff;
   logic [RES_W-1:0]  j_ff;
   logic [PCNT_W-1:0] count_ff;
   logic [STAT_W-1:0] emit_stat_ff;
   logic              rsp_valid_ff, rsp_last_ff;
   logic [STAT_W-1:0] rsp_stat_ff;
   logic [SEQP_W-1:0] rsp_seq_ff;

   logic [PCNT_W-1:0] n_eff;
   logic [RCNT_W-1:0] r_eff;
   logic j_last, i_last, rsp_free, req_fire;
   logic [PROC_W-1:0] cur_proc;
   logic [ADDR_W-1:0] rd_addr, wr_addr;
   logic max_we, alloc_we;
   count_type max_wd, alloc_wd, max_rd, alloc_rd, max_q, alloc_q;
   logic [COUNT_BITS:0] req_plus_alloc;
   logic [WORK_W:0]     alloc_plus_work;

   always_comb begin
      if (num_procs_ff == '0) begin
         n_eff = PCNT_W'(1);
      end else if (PCNT_W'(num_procs_ff) > PCNT_W'(MAX_PROCS)) begin
         n_eff = PCNT_W'(MAX_PROCS);
      end else begin
         n_eff = PCNT_W'(num_procs_ff);
      end
      if (num_res_ff == '0) begin
         r_eff = RCNT_W'(1);
      end else if (RCNT_W'(num_res_ff) > RCNT_W'(MAX_RES_TYPES)) begin
         r_eff = RCNT_W'(MAX_RES_TYPES);
      end else begin
         r_eff = RCNT_W'(num_res_ff);
      end
   end

   assign j_last   = (RCNT_W'(j_ff) == r_eff - RCNT_W'(1));
   assign i_last   = (PCNT_W'(i_ff) == n_eff - PCNT_W'(1));
   assign rsp_free = !rsp_valid_ff || rsp_chan.ready;
   assign req_chan.ready = (state_ff == ST_IDLE);
   assign req_fire = req_chan.valid && req_chan.ready;
   assign csr_chan.ready = 1'b1;

   assign rsp_chan.valid       = rsp_valid_ff;
   assign rsp_chan.status      = rsp_stat_ff;
   assign rsp_chan.seq_process = rsp_seq_ff;
   assign rsp_chan.last        = rsp_last_ff;

   assign cur_proc = grant_ff && (state_ff == ST_GRD || state_ff == ST_ARD ||
                                  state_ff == ST_RRD) ? proc_ff : i_ff;
   assign rd_addr  = {cur_proc, j_ff};
   assign max_q    = max_rv_ff ? max_rd : '0;
   assign alloc_q  = alloc_rv_ff ? alloc_rd : '0;
   assign req_plus_alloc  = {1'b0, req_ff[j_ff]} + {1'b0, alloc_q};
   assign alloc_plus_work = (WORK_W+1)'(alloc_q) + (WORK_W+1)'(work_ff[j_ff]);

   always_comb begin
      max_we   = 1'b0;
      alloc_we = 1'b0;
      wr_addr  = {req_chan.proc_index[PROC_W-1:0], req_chan.res_index[RES_W-1:0]};
      max_wd   = req_chan.value[COUNT_BITS-1:0];
      alloc_wd = req_chan.value[COUNT_BITS-1:0];
      if (req_fire && func_type'(req_chan.func) == FUNC_WR_MAX) begin
         max_we = 1'b1;
      end
      if (req_fire && func_type'(req_chan.func) == FUNC_WR_ALLOC) begin
         alloc_we = 1'b1;
      end
      if (state_ff == ST_AEV) begin
         alloc_we = 1'b1;
         wr_addr  = {proc_ff, j_ff};
         alloc_wd = alloc_q + req_ff[j_ff];
      end
      if (state_ff == ST_REV) begin
         alloc_we = 1'b1;
         wr_addr  = {proc_ff, j_ff};
         alloc_wd = alloc_q - req_ff[j_ff];
      end
   end

   bsrc_ram #(.WIDTH(COUNT_BITS), .DEPTH(DEPTH)) u_max_ram (
      .clock(clock), .wr_en(max_we), .wr_addr(wr_addr), .wr_data(max_wd),
      .rd_addr(rd_addr), .rd_data(max_rd)
   );

   bsrc_ram #(.WIDTH(COUNT_BITS), .DEPTH(DEPTH)) u_alloc_ram (
      .clock(clock), .wr_en(alloc_we), .wr_addr(wr_addr), .wr_data(alloc_wd),
      .rd_addr(rd_addr), .rd_data(alloc_rd)
   );

   always_ff @(posedge clock) begin
      max_rv_ff   <= max_vld_ff[rd_addr];
      alloc_rv_ff <= alloc_vld_ff[rd_addr];
      if (max_we) begin
         max_vld_ff[wr_addr] <= 1'b1;
      end
      if (alloc_we) begin
         alloc_vld_ff[wr_addr] <= 1'b1;
      end
      if (csr_chan.valid) begin
         if (csr_chan.index == CSR_NUM_PROCS) begin
            num_procs_ff <= csr_chan.data[NPROC_W-1:0];
         end else begin
            num_res_ff <= csr_chan.data[NRES_W-1:0];
         end
      end
      if (rsp_valid_ff && rsp_chan.ready) begin
         rsp_valid_ff <= 1'b0;
      end

      unique case (state_ff)
         ST_IDLE: begin
            j_ff <= '0;
            if (req_fire) begin
               case (func_type'(req_chan.func))
                  FUNC_WR_AVAIL: avail_ff[req_chan.res_index[RES_W-1:0]] <=
                                    req_chan.value[COUNT_BITS-1:0];
                  FUNC_STAGE:    req_ff[req_chan.res_index[RES_W-1:0]] <=
                                    req_chan.value[COUNT_BITS-1:0];
                  FUNC_CHECK: begin
                     grant_ff <= 1'b0;
                     state_ff <= ST_INIT;
                  end
                  FUNC_GRANT: begin
                     grant_ff     <= 1'b1;
                     proc_ff      <= req_chan.proc_index[PROC_W-1:0];
                     need_err_ff  <= 1'b0;
                     avail_err_ff <= 1'b0;
                     if (PCNT_W'(req_chan.proc_index) >= n_eff) begin
                        emit_stat_ff <= STAT_OVER_NEED;
                        state_ff     <= ST_EMIT_ONE;
                     end else begin
                        state_ff <= ST_GRD;
                     end
                  end
                  default: ;
               endcase
            end
         end
         ST_GRD: state_ff <= ST_GEV;
         ST_GEV: begin
            if (req_plus_alloc > {1'b0, max_q}) begin
               need_err_ff <= 1'b1;
            end
            if (req_ff[j_ff] > avail_ff[j_ff]) begin
               avail_err_ff <= 1'b1;
            end
            if (j_last) begin
               j_ff     <= '0;
               state_ff <= ST_GEND;
            end else begin
               j_ff     <= j_ff + RES_W'(1);
               state_ff <= ST_GRD;
            end
         end
         ST_GEND: begin
            if (need_err_ff) begin
               emit_stat_ff <= STAT_OVER_NEED;
               state_ff     <= ST_EMIT_ONE;
            end else if (avail_err_ff) begin
               emit_stat_ff <= STAT_OVER_AVAIL;
               state_ff     <= ST_EMIT_ONE;
            end else begin
               state_ff <= ST_ARD;
            end
         end
         ST_ARD: state_ff <= ST_AEV;
         ST_AEV: begin
            avail_ff[j_ff] <= avail_ff[j_ff] - req_ff[j_ff];
            if (j_last) begin
               j_ff     <= '0;
               state_ff <= ST_INIT;
            end else begin
               j_ff     <= j_ff + RES_W'(1);
               state_ff <= ST_ARD;
            end
         end
         ST_INIT: begin
            for (int r = 0; r < MAX_RES_TYPES; r++) begin
               work_ff[r] <= WORK_W'(avail_ff[r]);
            end
            fin_ff   <= '0;
            count_ff <= '0;
            i_ff     <= '0;
            j_ff     <= '0;
            found_ff <= 1'b0;
            state_ff <= ST_SRD;
         end
         ST_SRD: state_ff <= fin_ff[i_ff] ? ST_NEXT : ST_SEV;
         ST_SEV: begin
            if ((WORK_W+1)'(max_q) > alloc_plus_work) begin
               state_ff <= ST_NEXT;
            end else if (j_last) begin
               j_ff     <= '0;
               state_ff <= ST_WRD;
            end else begin
               j_ff     <= j_ff + RES_W'(1);
               state_ff <= ST_SRD;
            end
         end
         ST_WRD: state_ff <= ST_WEV;
         ST_WEV: begin
            work_ff[j_ff] <= alloc_plus_work[WORK_W-1:0];
            if (j_last) begin
               seq_ff[count_ff[PROC_W-1:0]] <= i_ff;
               fin_ff[i_ff] <= 1'b1;
               count_ff     <= count_ff + PCNT_W'(1);
               found_ff     <= 1'b1;
               state_ff     <= ST_NEXT;
            end else begin
               j_ff     <= j_ff + RES_W'(1);
               state_ff <= ST_WRD;
            end
         end
         ST_NEXT: begin
            j_ff <= '0;
            if (count_ff == n_eff) begin
               k_ff     <= '0;
               state_ff <= ST_EMIT_SEQ;
            end else if (i_last) begin
               if (!found_ff) begin
                  emit_stat_ff <= STAT_UNSAFE;
                  state_ff     <= grant_ff ? ST_RRD : ST_EMIT_ONE;
               end else begin
                  i_ff     <= '0;
                  found_ff <= 1'b0;
                  state_ff <= ST_SRD;
               end
            end else begin
               i_ff     <= i_ff + PROC_W'(1);
               state_ff <= ST_SRD;
            end
         end
         ST_RRD: state_ff <= ST_REV;
         ST_REV: begin
            avail_ff[j_ff] <= avail_ff[j_ff] + req_ff[j_ff];
            if (j_last) begin
               state_ff <= ST_EMIT_ONE;
            end else begin
               j_ff     <= j_ff + RES_W'(1);
               state_ff <= ST_RRD;
            end
         end
         ST_EMIT_SEQ: begin
            if (rsp_free) begin
               rsp_valid_ff <= 1'b1;
               rsp_stat_ff  <= STAT_SAFE;
               rsp_seq_ff   <= SEQP_W'(seq_ff[k_ff]);
               rsp_last_ff  <= (PCNT_W'(k_ff) == n_eff - PCNT_W'(1));
               if (PCNT_W'(k_ff) == n_eff - PCNT_W'(1)) begin
                  state_ff <= ST_IDLE;
               end else begin
                  k_ff <= k_ff + PROC_W'(1);
               end
            end
         end
         ST_EMIT_ONE: begin
            if (rsp_free) begin
               rsp_valid_ff <= 1'b1;
               rsp_stat_ff  <= emit_stat_ff;
               rsp_seq_ff   <= '0;
               rsp_last_ff  <= 1'b1;
               state_ff     <= ST_IDLE;
            end
         end
         default: state_ff <= ST_IDLE;
      endcase

      if (reset) begin
         state_ff     <= ST_IDLE;
         num_procs_ff <= NPROC_W'(MAX_PROCS);
         num_res_ff   <= NRES_W'(MAX_RES_TYPES);
         rsp_valid_ff <= 1'b0;
         max_vld_ff   <= '0;
         alloc_vld_ff <= '0;
         fin_ff       <= '0;
         count_ff     <= '0;
         for (int r = 0; r < MAX_RES_TYPES; r++) begin
            avail_ff[r] <= '0;
            req_ff[r]   <= '0;
         end
      end
   end

   a_err_is_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_stat_ff != STAT_SAFE |-> rsp_last_ff)
      else $error("error status without last");
   a_err_no_proc: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_stat_ff != STAT_SAFE |-> rsp_seq_ff == '0)
      else $error("error status with a process number");
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_NEXT |-> count_ff <= n_eff)
      else $error("sequence count beyond processes in use");
   a_stall_holds: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_EMIT_ONE && !rsp_free |=> state_ff == ST_EMIT_ONE)
      else $error("result dropped while stalled");
endmodule
`default_nettype wire

// ----- hdl/bsrc_ram.sv -----
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
`default_nettype none
module bsrc_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 128
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end
endmodule
`default_nettype wire
